### hw/rtl/rbht_pkg.sv
`default_nettype none
package rbht_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = 16;
    localparam int QUO_W   = 32;
    localparam int NAXES   = 3;

    typedef logic [NAXES-1:0][COORD_W-1:0] t_vec3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_origin_z;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] ray_dir_z;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } t_ray_box;

    typedef struct packed {
        logic hit;
    } t_hit;

    typedef logic [TOL_W-1:0] t_tol;

    typedef struct packed {
        t_vec3            org;
        t_vec3            dir;
        t_vec3            bmin;
        t_vec3            bmax;
        logic [NAXES-1:0] cand;
        logic             null_box;
        logic             in_box;
    } t_ctx;

endpackage
`default_nettype wire

### hw/rtl/rbht_if.sv
`default_nettype none
interface rbht_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/rbht_front.sv
`default_nettype none
module rbht_front
    import rbht_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int RW        = 63
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire t_ray_box                   i_word,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output t_ctx                            o_ctx,
    output logic [NAXES-1:0][RW-1:0]        o_rem,
    output logic [NAXES-1:0][COORD_W-1:0]   o_den
);
    logic                          r_valid;
    t_ctx                          r_ctx, n_ctx;
    logic [NAXES-1:0][RW-1:0]      r_rem, n_rem;
    logic [NAXES-1:0][COORD_W-1:0] r_den, n_den;

    always_comb begin
        logic signed [COORD_W:0] v_diff;
        logic signed [COORD_W:0] v_mag;
        logic                    v_below;
        logic                    v_above;
        n_ctx.org  = {i_word.ray_origin_z, i_word.ray_origin_y, i_word.ray_origin_x};
        n_ctx.dir  = {i_word.ray_dir_z, i_word.ray_dir_y, i_word.ray_dir_x};
        n_ctx.bmin = {i_word.box_min_z, i_word.box_min_y, i_word.box_min_x};
        n_ctx.bmax = {i_word.box_max_z, i_word.box_max_y, i_word.box_max_x};
        n_ctx.null_box = (n_ctx.bmin == n_ctx.bmax);
        n_ctx.in_box   = 1'b1;
        for (int a = 0; a < NAXES; a++) begin
            v_below = $signed(n_ctx.org[a]) < $signed(n_ctx.bmin[a]);
            v_above = $signed(n_ctx.org[a]) > $signed(n_ctx.bmax[a]);
            if (v_below || v_above) begin
                n_ctx.in_box = 1'b0;
            end
            if (v_below) begin
                v_diff = (COORD_W+1)'($signed(n_ctx.bmin[a])) - (COORD_W+1)'($signed(n_ctx.org[a]));
            end else begin
                v_diff = (COORD_W+1)'($signed(n_ctx.org[a])) - (COORD_W+1)'($signed(n_ctx.bmax[a]));
            end
            v_mag = $signed(n_ctx.dir[a]) < 0 ? -(COORD_W+1)'($signed(n_ctx.dir[a]))
                                              : (COORD_W+1)'($signed(n_ctx.dir[a]));
            n_ctx.cand[a] = v_below ? ($signed(n_ctx.dir[a]) > 0)
                                    : (v_above && $signed(n_ctx.dir[a]) < 0);
            n_rem[a] = RW'(v_diff[COORD_W-1:0]) << FRAC_BITS;
            n_den[a] = v_mag[COORD_W-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctx <= n_ctx;
            r_rem <= n_rem;
            r_den <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
endmodule
`default_nettype wire

### hw/rtl/rbht_div_step.sv
`default_nettype none
module rbht_div_step
    import rbht_pkg::*;
#(
    parameter int RW  = 63,
    parameter int BIT = 31
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire t_ctx                             i_ctx,
    input  wire logic [NAXES-1:0][RW-1:0]         i_rem,
    input  wire logic [NAXES-1:0][COORD_W-1:0]    i_den,
    input  wire logic [NAXES-1:0][QUO_W-1:0]      i_quo,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output t_ctx                                  o_ctx,
    output logic [NAXES-1:0][RW-1:0]              o_rem,
    output logic [NAXES-1:0][COORD_W-1:0]         o_den,
    output logic [NAXES-1:0][QUO_W-1:0]           o_quo
);
    logic                            r_valid;
    t_ctx                            r_ctx;
    logic [NAXES-1:0][RW-1:0]        r_rem, n_rem;
    logic [NAXES-1:0][COORD_W-1:0]   r_den;
    logic [NAXES-1:0][QUO_W-1:0]     r_quo, n_quo;

    always_comb begin
        logic [RW-1:0] v_sh;
        for (int a = 0; a < NAXES; a++) begin
            v_sh     = RW'(i_den[a]) << BIT;
            n_quo[a] = i_quo[a];
            if (i_rem[a] >= v_sh) begin
                n_rem[a]      = i_rem[a] - v_sh;
                n_quo[a][BIT] = 1'b1;
            end else begin
                n_rem[a] = i_rem[a];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctx <= i_ctx;
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
endmodule
`default_nettype wire

### hw/rtl/rbht_back.sv
`default_nettype none
module rbht_back
    import rbht_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_tol                          i_tol,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire t_ctx                          i_ctx,
    input  wire logic [NAXES-1:0][QUO_W-1:0]   i_quo,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output t_hit                               o_word
);
    localparam logic [COORD_W-1:0] T_NONE   = ~((COORD_W'(1) << FRAC_BITS) - COORD_W'(1));
    localparam logic [COORD_W-1:0] T_SAT    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam int                 PW       = 2 * COORD_W;

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: entry plane
    logic [COORD_W-1:0]          r1_tp,   n1_tp;
    logic [1:0][COORD_W-1:0]     r1_dir,  n1_dir;
    logic [1:0][COORD_W-1:0]     r1_org,  n1_org;
    logic [1:0][COORD_W-1:0]     r1_bmin, n1_bmin;
    logic [1:0][COORD_W-1:0]     r1_bmax, n1_bmax;
    logic                        r1_null, r1_in_box;

    always_comb begin
        logic [NAXES-1:0][COORD_W-1:0] v_t;
        logic [1:0]                    v_plane;
        logic [1:0]                    v_a;
        logic [1:0]                    v_b;
        for (int a = 0; a < NAXES; a++) begin
            if (!i_ctx.cand[a]) begin
                v_t[a] = T_NONE;
            end else if (i_quo[a][QUO_W-1]) begin
                v_t[a] = T_SAT;
            end else begin
                v_t[a] = {1'b0, i_quo[a][QUO_W-2:0]};
            end
        end
        v_plane = 2'd0;
        if ($signed(v_t[1]) > $signed(v_t[0])) begin
            v_plane = 2'd1;
        end
        if ($signed(v_t[2]) > $signed(v_t[v_plane])) begin
            v_plane = 2'd2;
        end
        v_a = (v_plane == 2'd0) ? 2'd1 : 2'd0;
        v_b = (v_plane == 2'd2) ? 2'd1 : 2'd2;
        n1_tp   = v_t[v_plane];
        n1_dir  = {i_ctx.dir[v_b],  i_ctx.dir[v_a]};
        n1_org  = {i_ctx.org[v_b],  i_ctx.org[v_a]};
        n1_bmin = {i_ctx.bmin[v_b], i_ctx.bmin[v_a]};
        n1_bmax = {i_ctx.bmax[v_b], i_ctx.bmax[v_a]};
    end

    assign rdy1 = !r1_valid || rdy2;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy4 = !r4_valid || i_ready;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_tp     <= n1_tp;
            r1_dir    <= n1_dir;
            r1_org    <= n1_org;
            r1_bmin   <= n1_bmin;
            r1_bmax   <= n1_bmax;
            r1_null   <= i_ctx.null_box;
            r1_in_box <= i_ctx.in_box;
        end
    end

    // stage 2: products
    logic [1:0][PW-1:0]      r2_prod;
    logic [1:0][COORD_W-1:0] r2_org, r2_bmin, r2_bmax;
    logic                    r2_null, r2_in_box, r2_neg;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int k = 0; k < 2; k++) begin
                r2_prod[k] <= PW'($signed(r1_tp) * $signed(r1_dir[k]));
            end
            r2_org    <= r1_org;
            r2_bmin   <= r1_bmin;
            r2_bmax   <= r1_bmax;
            r2_null   <= r1_null;
            r2_in_box <= r1_in_box;
            r2_neg    <= r1_tp[COORD_W-1];
        end
    end

    // stage 3: entry point and bounds
    logic [1:0][PW-1:0] r3_f, r3_lo, r3_hi;
    logic               r3_null, r3_in_box, r3_neg;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int k = 0; k < 2; k++) begin
                r3_f[k]  <= PW'($signed(r2_org[k])) + PW'($signed(r2_prod[k]) >>> FRAC_BITS);
                r3_lo[k] <= PW'($signed(r2_bmin[k])) - PW'(i_tol);
                r3_hi[k] <= PW'($signed(r2_bmax[k])) + PW'(i_tol);
            end
            r3_null   <= r2_null;
            r3_in_box <= r2_in_box;
            r3_neg    <= r2_neg;
        end
    end

    // stage 4: verdict
    logic r4_hit, n4_hit;

    always_comb begin
        logic v_ok;
        v_ok = 1'b1;
        for (int k = 0; k < 2; k++) begin
            if ($signed(r3_f[k]) < $signed(r3_lo[k]) || $signed(r3_f[k]) > $signed(r3_hi[k])) begin
                v_ok = 1'b0;
            end
        end
        if (r3_null) begin
            n4_hit = 1'b0;
        end else if (r3_in_box) begin
            n4_hit = 1'b1;
        end else if (r3_neg) begin
            n4_hit = 1'b0;
        end else begin
            n4_hit = v_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_hit <= n4_hit;
        end
    end

    assign o_valid    = r4_valid;
    assign o_word.hit = r4_hit;
endmodule
`default_nettype wire

### hw/rtl/ray_box_hit_test_core.sv
// Ray against axis-aligned box hit test, signed fixed point coordinates.
// i_ray: one word per test, ray origin and direction plus box min and max.
// o_hit: one word per test, hit flag, in the order the tests arrived.
// i_cfg: write of edge_tolerance, always ready; write only while idle.
// The pipeline has 1 classify stage, 32 restoring division steps and
// 4 plane/multiply/compare stages. Throughput: one test per cycle unless
// o_hit stalls, set by the fully pipelined divider with one quotient bit
// per stage and one multiplier per lateral axis.
// Each stage advances when empty or when the next stage moves, so bubbles
// close up and i_ray stays ready while the output word waits.
// When o_hit is stalled the pipeline fills up and then drops i_ray.ready;
// no word is lost or repeated.
// Reset clears all valid bits and sets edge_tolerance to one.
`default_nettype none
module ray_box_hit_test_core
    import rbht_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbht_if.sink      i_ray,
    rbht_if.sink      i_cfg,
    rbht_if.source    o_hit
);
    localparam int RW     = (COORD_W + COORD_FRAC_BITS > 2 * COORD_W - 1) ?
                            COORD_W + COORD_FRAC_BITS : 2 * COORD_W - 1;
    localparam int NSTEPS = QUO_W;

    t_tol r_edge_tol;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_tol <= t_tol'(1);
        end else if (i_cfg.valid) begin
            r_edge_tol <= t_tol'(i_cfg.data);
        end
    end

    logic                          w_valid [NSTEPS+1];
    logic                          w_ready [NSTEPS+1];
    t_ctx                          w_ctx   [NSTEPS+1];
    logic [NAXES-1:0][RW-1:0]      w_rem   [NSTEPS+1];
    logic [NAXES-1:0][COORD_W-1:0] w_den   [NSTEPS+1];
    logic [NAXES-1:0][QUO_W-1:0]   w_quo   [NSTEPS+1];

    rbht_front #(
        .FRAC_BITS (COORD_FRAC_BITS),
        .RW        (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_ray.valid),
        .o_ready (i_ray.ready),
        .i_word  (i_ray.data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ctx   (w_ctx[0]),
        .o_rem   (w_rem[0]),
        .o_den   (w_den[0])
    );

    assign w_quo[0] = '0;

    for (genvar s = 0; s < NSTEPS; s++) begin : g_div
        rbht_div_step #(
            .RW  (RW),
            .BIT (NSTEPS - 1 - s)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_ctx   (w_ctx[s]),
            .i_rem   (w_rem[s]),
            .i_den   (w_den[s]),
            .i_quo   (w_quo[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_ctx   (w_ctx[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_den   (w_den[s+1]),
            .o_quo   (w_quo[s+1])
        );
    end

    rbht_back #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_edge_tol),
        .i_valid (w_valid[NSTEPS]),
        .o_ready (w_ready[NSTEPS]),
        .i_ctx   (w_ctx[NSTEPS]),
        .i_quo   (w_quo[NSTEPS]),
        .o_valid (o_hit.valid),
        .i_ready (o_hit.ready),
        .o_word  (o_hit.data)
    );
endmodule
`default_nettype wire
